@@ hw/rtl/bd4n_pkg.sv @@
// Shared constants, types and the neighbor weight table of the cross-shaped bilateral filter.
package bd4n_pkg;

	localparam int MaxWidth     = 2048;
	localparam int MaxHeight    = 2048;
	localparam int ColW         = $clog2(MaxWidth);
	localparam int RowW         = $clog2(MaxHeight);
	localparam int DimW         = 12;
	localparam int PixW         = 8;
	localparam int LineW        = 2 * PixW;
	localparam int SigmaColor   = 20;
	localparam int SigmaSpace   = 3;
	localparam int WeightFrac   = 16;
	localparam int WeightW      = WeightFrac + 1;
	localparam int ProdW        = WeightW + PixW;
	localparam int NumW         = ProdW + 2;
	localparam int DenW         = WeightFrac + 3;
	localparam int RemW         = NumW + 2;
	localparam int DvsW         = DenW + 1;
	localparam int DivSteps     = PixW;
	localparam int FifoDepth    = 16;
	localparam int FifoAw       = $clog2(FifoDepth);
	localparam int RegAddrW     = 3;
	localparam int DataW        = 32;
	localparam int WidthReset   = 640;
	localparam int HeightReset  = 480;
	localparam int NumNbr       = 4;

	localparam longint unsigned OneQ30   = 64'd1 << 30;
	localparam longint unsigned WtDen    = 64'(2 * SigmaSpace * SigmaSpace
		* SigmaColor * SigmaColor);
	localparam int              MaxExpQ  = 40;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// control that rides along with one transaction
	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
		logic wr;
	} ctl_t;

	// one step of the quotient pipeline
	typedef struct packed {
		logic              vld;
		ctl_t              ctl;
		logic [PixW-1:0]   c;
		logic [RemW-1:0]   rem;
		logic [DvsW-1:0]   dvs;
		logic [PixW-1:0]   quo;
	} div_t;

	typedef logic [WeightW-1:0] weight_rom_t [256];

	// exp(-f) in Q30 by an alternating Taylor sum
	function automatic longint unsigned exp_neg_q30(longint unsigned fq);
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		term = OneQ30;
		pos  = OneQ30;
		neg  = 64'd0;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * fq) >> 30) / 64'(k);
			if (k[0]) neg += term;
			else pos += term;
		end
		return (pos > neg) ? (pos - neg) : 64'd0;
	endfunction

	function automatic logic [WeightW-1:0] make_weight(longint unsigned d);
		longint unsigned num;
		longint unsigned q;
		longint unsigned r;
		longint unsigned v;
		longint unsigned e1;
		longint unsigned rnd;
		num = 64'(SigmaColor * SigmaColor) + d * d * 64'(SigmaSpace * SigmaSpace);
		q   = num / WtDen;
		r   = num - q * WtDen;
		if (q > 64'(MaxExpQ)) return '0;
		v  = exp_neg_q30((r << 30) / WtDen);
		e1 = exp_neg_q30(OneQ30);
		for (int i = 0; i <= MaxExpQ; i++) begin
			if (64'(i) < q) v = (v * e1) >> 30;
		end
		rnd = (v + (64'd1 << (29 - WeightFrac))) >> (30 - WeightFrac);
		return rnd[WeightW-1:0];
	endfunction

	function automatic weight_rom_t build_rom();
		weight_rom_t rom;
		for (int d = 0; d < 256; d++) begin
			rom[d] = make_weight(64'(d));
		end
		return rom;
	endfunction

	localparam weight_rom_t WeightRom = build_rom();

endpackage

@@ hw/rtl/bilateral_denoise_4nbr.sv @@
// Top level of the streaming cross-shaped bilateral filter for 8-bit luma.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+---------------------------
//   input     | in        | in_valid/in_stall  | op, pixel_in
//   output    | out       | out_valid/out_stall| pixel_out, last_of_frame
//   config    | in        | APB psel..pready   | frame_width, frame_height
//
// One transaction per clock. Each accepted transaction reads two entries of
// the line memory (column and column+1) and a pixel writes one back; a one-deep
// forward covers the write in flight. Results pass through stages 1 to 4 and
// the quotient pipeline into a 16-entry output queue; input stalls only when
// queued plus in-flight results fill that queue. Reset clears counters and
// queue; line memory needs no clearing.
module bilateral_denoise_4nbr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [bd4n_pkg::PixW-1:0]        pixel_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bd4n_pkg::PixW-1:0]        pixel_out,
	output logic                             last_of_frame,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bd4n_pkg::RegAddrW-1:0]    paddr,
	input  logic [bd4n_pkg::DataW-1:0]       pwdata,
	output logic [bd4n_pkg::DataW-1:0]       prdata,
	output logic                             pready
);
	import bd4n_pkg::*;

	// configuration registers
	logic [DimW-1:0] frame_width_q;
	logic [DimW-1:0] frame_height_q;
	logic [DimW-1:0] eff_w;
	logic [DimW-1:0] eff_h;
	reg_idx_t        reg_idx;

	// stream position
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic            draining_q;

	// stage 0 decode
	logic            accept;
	logic            take;
	logic            is_pixel;
	logic [DimW-1:0] col_nx;
	logic [DimW-1:0] row_nx;
	logic            last_col;
	ctl_t            ctl0;
	logic [ColW-1:0] ra1;

	// line memory: {row r-2, row r-1} per column
	logic [LineW-1:0] line_mem [MaxWidth];

	// stage 1
	logic             vld_s1;
	ctl_t             ctl_s1;
	logic [ColW-1:0]  col_s1;
	logic [PixW-1:0]  px_s1;
	logic [LineW-1:0] rd0_s1;
	logic [LineW-1:0] rd1_s1;
	logic             fwd0_s1;
	logic             fwd1_s1;
	logic [LineW-1:0] fwdd_s1;
	logic [LineW-1:0] ent0;
	logic [LineW-1:0] ent1;
	logic [LineW-1:0] wd_s1;
	logic [PixW-1:0]  left_q;
	logic [PixW-1:0]  nbr [NumNbr];
	logic [PixW-1:0]  diff [NumNbr];

	// stage 2
	logic             vld_s2;
	ctl_t             ctl_s2;
	logic [PixW-1:0]  c_s2;
	logic [PixW-1:0]  nbr_s2 [NumNbr];
	logic [WeightW-1:0] w_s2 [NumNbr];

	// stage 3
	logic             vld_s3;
	ctl_t             ctl_s3;
	logic [PixW-1:0]  c_s3;
	logic [ProdW-1:0] prod_s3 [NumNbr];
	logic [WeightW-1:0] w_s3 [NumNbr];

	// stage 4
	logic             vld_s4;
	ctl_t             ctl_s4;
	logic [PixW-1:0]  c_s4;
	logic [NumW-1:0]  num_s4;
	logic [DenW-1:0]  den_s4;
	logic [NumW-1:0]  num_sum;
	logic [DenW-1:0]  den_sum;

	// quotient pipeline
	div_t             div_q [DivSteps+1];
	div_t             div_nx [DivSteps];

	// output queue and credit
	logic [PixW:0]     fifo_mem [FifoDepth];
	logic [FifoAw-1:0] wptr_q;
	logic [FifoAw-1:0] rptr_q;
	logic [FifoAw:0]   fifo_cnt_q;
	logic [FifoAw:0]   credit_q;
	logic              push;
	logic              pop;
	logic [PixW-1:0]   res_px;

	// clamp configuration to the supported frame size
	always_comb begin
		if (frame_width_q == '0) eff_w = DimW'(1);
		else if (frame_width_q > DimW'(MaxWidth)) eff_w = DimW'(MaxWidth);
		else eff_w = frame_width_q;
		if (frame_height_q == '0) eff_h = DimW'(1);
		else if (frame_height_q > DimW'(MaxHeight)) eff_h = DimW'(MaxHeight);
		else eff_h = frame_height_q;
	end

	// APB register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = DataW'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = DataW'(frame_height_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DimW'(WidthReset);
			frame_height_q <= DimW'(HeightReset);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DimW-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[DimW-1:0];
				default:          ;
			endcase
		end
	end

	// decode the transaction against the stream position
	assign in_stall = (credit_q >= (FifoAw+1)'(FifoDepth));
	assign accept   = in_valid && !in_stall;
	assign is_pixel = (op_t'(op) == OP_PIXEL);
	assign take     = accept && (is_pixel ? !draining_q : draining_q);
	assign col_nx   = {1'b0, col_q} + DimW'(1);
	assign row_nx   = {1'b0, row_q} + DimW'(1);
	assign last_col = (col_nx >= eff_w);
	assign ra1      = col_nx[ColW-1:0];

	always_comb begin
		ctl0.wr       = is_pixel;
		ctl0.emit     = is_pixel ? (row_q != '0) : 1'b1;
		ctl0.last     = !is_pixel && last_col;
		ctl0.interior = is_pixel && (row_q >= RowW'(2)) && ({1'b0, row_q} < eff_h)
			&& (col_q != '0) && (col_nx < eff_w);
	end

	// advance column, row and drain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
		end else if (take) begin
			if (!last_col) begin
				col_q <= ra1;
			end else begin
				col_q <= '0;
				if (!is_pixel) begin
					row_q      <= '0;
					draining_q <= 1'b0;
				end else if (row_nx >= eff_h) begin
					row_q      <= '0;
					draining_q <= 1'b1;
				end else begin
					row_q <= row_nx[RowW-1:0];
				end
			end
		end
	end

	// line memory: two reads, one write
	always_ff @(posedge clk) begin
		rd0_s1 <= line_mem[col_q];
		rd1_s1 <= line_mem[ra1];
		if (vld_s1 && ctl_s1.wr) line_mem[col_s1] <= wd_s1;
	end

	// stage 1 registers, with forward of the write in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= take;
	end

	always_ff @(posedge clk) begin
		ctl_s1  <= ctl0;
		col_s1  <= col_q;
		px_s1   <= pixel_in;
		fwd0_s1 <= vld_s1 && ctl_s1.wr && (col_s1 == col_q);
		fwd1_s1 <= vld_s1 && ctl_s1.wr && (col_s1 == ra1);
		fwdd_s1 <= wd_s1;
		if (vld_s1 && ctl_s1.wr) left_q <= ent0[PixW-1:0];
	end

	// resolve neighbors and look up weights
	always_comb begin
		ent0  = fwd0_s1 ? fwdd_s1 : rd0_s1;
		ent1  = fwd1_s1 ? fwdd_s1 : rd1_s1;
		wd_s1 = {ent0[PixW-1:0], px_s1};
		nbr[0] = ent1[PixW-1:0];
		nbr[1] = ent0[LineW-1:PixW];
		nbr[2] = left_q;
		nbr[3] = px_s1;
		for (int i = 0; i < NumNbr; i++) begin
			diff[i] = (ent0[PixW-1:0] >= nbr[i]) ? (ent0[PixW-1:0] - nbr[i])
				: (nbr[i] - ent0[PixW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// weights, products, then sums
	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		c_s2   <= ent0[PixW-1:0];
		for (int i = 0; i < NumNbr; i++) begin
			nbr_s2[i] <= nbr[i];
			w_s2[i]   <= WeightRom[diff[i]];
		end
		ctl_s3 <= ctl_s2;
		c_s3   <= c_s2;
		for (int i = 0; i < NumNbr; i++) begin
			prod_s3[i] <= ProdW'(w_s2[i]) * ProdW'(nbr_s2[i]);
			w_s3[i]    <= w_s2[i];
		end
		ctl_s4 <= ctl_s3;
		c_s4   <= c_s3;
		num_s4 <= num_sum;
		den_s4 <= den_sum;
	end

	always_comb begin
		num_sum = NumW'({c_s3, WeightFrac'(0)});
		den_sum = DenW'(1) << WeightFrac;
		for (int i = 0; i < NumNbr; i++) begin
			num_sum = num_sum + NumW'(prod_s3[i]);
			den_sum = den_sum + DenW'(w_s3[i]);
		end
	end

	// one quotient bit per stage, rounding folded into the dividend
	always_comb begin
		for (int j = 0; j < DivSteps; j++) begin
			div_nx[j] = div_q[j];
			if (div_q[j].rem >= (RemW'(div_q[j].dvs) << (DivSteps-1-j))) begin
				div_nx[j].rem = div_q[j].rem - (RemW'(div_q[j].dvs) << (DivSteps-1-j));
				div_nx[j].quo[DivSteps-1-j] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= DivSteps; j++) div_q[j] <= '0;
		end else begin
			div_q[0].vld <= vld_s4;
			div_q[0].ctl <= ctl_s4;
			div_q[0].c   <= c_s4;
			div_q[0].rem <= RemW'({num_s4, 1'b0}) + RemW'(den_s4);
			div_q[0].dvs <= {den_s4, 1'b0};
			div_q[0].quo <= '0;
			for (int j = 0; j < DivSteps; j++) div_q[j+1] <= div_nx[j];
		end
	end

	// output queue
	assign res_px    = div_q[DivSteps].ctl.interior ? div_q[DivSteps].quo : div_q[DivSteps].c;
	assign push      = div_q[DivSteps].vld && div_q[DivSteps].ctl.emit;
	assign out_valid = (fifo_cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign pixel_out     = fifo_mem[rptr_q][PixW-1:0];
	assign last_of_frame = fifo_mem[rptr_q][PixW];

	always_ff @(posedge clk) begin
		if (push) fifo_mem[wptr_q] <= {div_q[DivSteps].ctl.last, res_px};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q     <= '0;
			rptr_q     <= '0;
			fifo_cnt_q <= '0;
			credit_q   <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + FifoAw'(1);
			if (pop) rptr_q <= rptr_q + FifoAw'(1);
			fifo_cnt_q <= fifo_cnt_q + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
			credit_q   <= credit_q + (FifoAw+1)'(take && ctl0.emit) - (FifoAw+1)'(pop);
		end
	end

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_cnt_q != (FifoAw+1)'(FifoDepth)) || pop)
		else $error("output queue overflow");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q >= fifo_cnt_q)
		else $error("credit below queue occupancy");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(draining_q) |-> (col_q == '0) && (row_q == '0))
		else $error("drain started off frame origin");

endmodule
